>>> rtl/npcs_pkg.sv
// Types, constants and helpers shared by the NAND page command sequencer.
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

  localparam int unsigned PAYLOAD_BYTES = 512;
  localparam int unsigned SPARE_BYTES   = 8;
  localparam int unsigned PAGE_SHIFT    = 8;
  localparam int unsigned MAX_RESULTS   = 9;
  localparam int unsigned BC_W          = 10;
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] SPARE_COLUMN_RST = 16'h1000;

  // NAND command opcodes
  localparam logic [7:0] NAND_RESET      = 8'hFF;
  localparam logic [7:0] NAND_ERASE_1    = 8'h60;
  localparam logic [7:0] NAND_ERASE_2    = 8'hD0;
  localparam logic [7:0] NAND_PROG_1     = 8'h80;
  localparam logic [7:0] NAND_CHG_WCOL   = 8'h85;
  localparam logic [7:0] NAND_PROG_2     = 8'h10;
  localparam logic [7:0] NAND_READ_1     = 8'h00;
  localparam logic [7:0] NAND_READ_2     = 8'h30;
  localparam logic [7:0] NAND_CHG_RCOL_1 = 8'h05;
  localparam logic [7:0] NAND_CHG_RCOL_2 = 8'hE0;
  localparam logic [7:0] NAND_STATUS     = 8'h70;
  localparam int unsigned STATUS_RDY_BIT = 6;

  // register map
  localparam logic REG_SPARE_COLUMN = 1'b0;

  typedef enum logic [2:0] {
    CMD_RESET     = 3'd0,
    CMD_ERASE     = 3'd1,
    CMD_PROGRAM   = 3'd2,
    CMD_READ      = 3'd3,
    CMD_HOST_DATA = 3'd4,
    CMD_FLASH_BYTE = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_CMD    = 3'd0,
    KIND_ADDR   = 3'd1,
    KIND_WDATA  = 3'd2,
    KIND_STROBE = 3'd3,
    KIND_HOST   = 3'd4,
    KIND_DONE   = 3'd5,
    KIND_REJECT = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_WAIT     = 4'd1,
    PH_PROG_PAY = 4'd2,
    PH_PROG_SPR = 4'd3,
    PH_READ_PAY = 4'd4,
    PH_READ_SPR = 4'd5
  } phase_e;

  // what one accepted word does
  typedef enum logic [3:0] {
    ACT_REJECT,
    ACT_RESET,
    ACT_ERASE,
    ACT_PROG,
    ACT_READ,
    ACT_POLL,
    ACT_READ_START,
    ACT_FINISH,
    ACT_PROG_BYTE,
    ACT_PROG_TO_SPR,
    ACT_SPR_BYTE,
    ACT_SPR_END,
    ACT_RD_BYTE,
    ACT_RD_TO_SPR,
    ACT_RSPR_BYTE,
    ACT_RSPR_END
  } act_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] bus_byte;
  } res_t;

  function automatic res_t mk(kind_e kind, logic [7:0] bus_byte);
    res_t r;
    r.kind     = kind;
    r.bus_byte = bus_byte;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/nand_page_command_sequencer.sv
// Top level: NAND page command sequencer with result buffer and APB register.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Slave stream: one word per host request, host data byte or byte returned
//   by the flash; tuser carries the command code. Master stream: one word per
//   NAND bus cycle (command, address, write data, read strobe), plus host
//   read bytes and done / rejected markers; tuser carries the cycle kind and
//   tlast marks the final word caused by an input word.
//   APB: one register, spare_column at byte address 0 (reset 0x1000).
//   Latency: the first result word is valid the cycle after the input word
//   is taken. An input word yields 1 to 9 result words, one per cycle while
//   m_axis_tready is high. The next input word is taken in the cycle the
//   last result of the previous one leaves, so single-result words stream
//   at one per cycle while m_axis_tready is high.
//   Reset: phase idle, byte count zero, chip enable off, buffer empty.
//   Stall: while m_axis_tready is low the head result holds, and no new
//   input word is taken until the final result of the run has left.
//   A word that does not fit the current phase gives one rejected result.

module nand_page_command_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [23:0] target_address, [31:24] data_byte
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] cmd
  // master stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,  // [7:0] bus_byte, [8] chip_enable, rest zero
  output      logic [2:0]  m_axis_tuser,  // [2:0] cycle_kind
  output      logic        m_axis_tlast,  // last_of_run
  // APB register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import npcs_pkg::*;

  // ---------------------------------------------------------------- config
  logic [15:0] spare_column_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SPARE_COLUMN);
  assign prdata = (paddr[2] == REG_SPARE_COLUMN) ? {16'h0000, spare_column_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spare_column_q <= SPARE_COLUMN_RST;
    end else if (cfg_wr) begin
      spare_column_q <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------- state
  phase_e          phase_q, phase_d;
  logic [BC_W-1:0] bc_q, bc_d;
  logic            op_is_read_q, op_is_read_d;
  logic            ce_q, ce_d;

  // result buffer: shift line, head at entry 0
  res_t            buf_q [MAX_RESULTS];
  res_t            list_d [MAX_RESULTS];
  logic [CNT_W-1:0] cnt_q, n_d;
  logic            run_ce_q;

  logic            in_acc, out_acc;
  cmd_e            cmd;
  logic [23:0]     addr;
  logic [7:0]      data;
  logic [BC_W-1:0] bc_inc;
  logic [23:0]     erase_row;
  act_e            act;

  assign cmd       = cmd_e'(s_axis_tuser);
  assign addr      = s_axis_tdata[23:0];
  assign data      = s_axis_tdata[31:24];
  assign bc_inc    = bc_q + BC_W'(1);
  assign erase_row = addr << PAGE_SHIFT;

  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  // decode: what this word does in the current phase
  always_comb begin
    act = ACT_REJECT;
    case (phase_q)
      PH_IDLE: begin
        case (cmd)
          CMD_RESET:   act = ACT_RESET;
          CMD_ERASE:   act = ACT_ERASE;
          CMD_PROGRAM: act = ACT_PROG;
          CMD_READ:    act = ACT_READ;
          default:     act = ACT_REJECT;
        endcase
      end
      PH_WAIT: begin
        if (cmd == CMD_FLASH_BYTE) begin
          if (!data[STATUS_RDY_BIT]) act = ACT_POLL;
          else if (op_is_read_q)     act = ACT_READ_START;
          else                       act = ACT_FINISH;
        end
      end
      PH_PROG_PAY: begin
        if (cmd == CMD_HOST_DATA) begin
          act = (bc_inc >= BC_W'(PAYLOAD_BYTES)) ? ACT_PROG_TO_SPR : ACT_PROG_BYTE;
        end
      end
      PH_PROG_SPR: begin
        if (cmd == CMD_HOST_DATA) begin
          act = (bc_inc >= BC_W'(SPARE_BYTES)) ? ACT_SPR_END : ACT_SPR_BYTE;
        end
      end
      PH_READ_PAY: begin
        if (cmd == CMD_FLASH_BYTE) begin
          act = (bc_inc < BC_W'(PAYLOAD_BYTES)) ? ACT_RD_BYTE : ACT_RD_TO_SPR;
        end
      end
      PH_READ_SPR: begin
        if (cmd == CMD_FLASH_BYTE) begin
          act = (bc_inc < BC_W'(SPARE_BYTES)) ? ACT_RSPR_BYTE : ACT_RSPR_END;
        end
      end
      default: act = ACT_REJECT;
    endcase
  end

  // next state
  always_comb begin
    phase_d      = phase_q;
    bc_d         = bc_q;
    op_is_read_d = op_is_read_q;
    ce_d         = ce_q;
    case (act)
      ACT_RESET: begin
        op_is_read_d = 1'b0;
        phase_d      = PH_WAIT;
      end
      ACT_ERASE: begin
        ce_d         = 1'b1;
        op_is_read_d = 1'b0;
        phase_d      = PH_WAIT;
      end
      ACT_PROG: begin
        ce_d         = 1'b1;
        op_is_read_d = 1'b0;
        bc_d         = '0;
        phase_d      = PH_PROG_PAY;
      end
      ACT_READ: begin
        ce_d         = 1'b1;
        op_is_read_d = 1'b1;
        phase_d      = PH_WAIT;
      end
      ACT_POLL: phase_d = PH_WAIT;
      ACT_READ_START: begin
        bc_d    = '0;
        phase_d = PH_READ_PAY;
      end
      ACT_FINISH, ACT_RSPR_END: begin
        ce_d         = 1'b0;
        op_is_read_d = 1'b0;
        bc_d         = '0;
        phase_d      = PH_IDLE;
      end
      ACT_PROG_BYTE, ACT_SPR_BYTE, ACT_RD_BYTE, ACT_RSPR_BYTE: bc_d = bc_inc;
      ACT_PROG_TO_SPR: begin
        bc_d    = '0;
        phase_d = PH_PROG_SPR;
      end
      ACT_SPR_END: begin
        bc_d    = '0;
        phase_d = PH_WAIT;
      end
      ACT_RD_TO_SPR: begin
        bc_d    = '0;
        phase_d = PH_READ_SPR;
      end
      default: ;
    endcase
  end

  // result list for this word
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) list_d[i] = mk(KIND_CMD, 8'h00);
    n_d = CNT_W'(1);
    case (act)
      ACT_RESET: begin
        list_d[0] = mk(KIND_CMD, NAND_RESET);
        list_d[1] = mk(KIND_CMD, NAND_STATUS);
        list_d[2] = mk(KIND_STROBE, 8'h00);
        n_d = CNT_W'(3);
      end
      ACT_ERASE: begin
        list_d[0] = mk(KIND_CMD, NAND_ERASE_1);
        list_d[1] = mk(KIND_ADDR, erase_row[7:0]);
        list_d[2] = mk(KIND_ADDR, erase_row[15:8]);
        list_d[3] = mk(KIND_ADDR, erase_row[23:16]);
        list_d[4] = mk(KIND_CMD, NAND_ERASE_2);
        list_d[5] = mk(KIND_CMD, NAND_STATUS);
        list_d[6] = mk(KIND_STROBE, 8'h00);
        n_d = CNT_W'(7);
      end
      ACT_PROG: begin
        list_d[0] = mk(KIND_CMD, NAND_PROG_1);
        list_d[1] = mk(KIND_ADDR, 8'h00);
        list_d[2] = mk(KIND_ADDR, 8'h00);
        list_d[3] = mk(KIND_ADDR, addr[7:0]);
        list_d[4] = mk(KIND_ADDR, addr[15:8]);
        list_d[5] = mk(KIND_ADDR, addr[23:16]);
        n_d = CNT_W'(6);
      end
      ACT_READ: begin
        list_d[0] = mk(KIND_CMD, NAND_READ_1);
        list_d[1] = mk(KIND_ADDR, 8'h00);
        list_d[2] = mk(KIND_ADDR, 8'h00);
        list_d[3] = mk(KIND_ADDR, addr[7:0]);
        list_d[4] = mk(KIND_ADDR, addr[15:8]);
        list_d[5] = mk(KIND_ADDR, addr[23:16]);
        list_d[6] = mk(KIND_CMD, NAND_READ_2);
        list_d[7] = mk(KIND_CMD, NAND_STATUS);
        list_d[8] = mk(KIND_STROBE, 8'h00);
        n_d = CNT_W'(9);
      end
      ACT_POLL: begin
        list_d[0] = mk(KIND_CMD, NAND_STATUS);
        list_d[1] = mk(KIND_STROBE, 8'h00);
        n_d = CNT_W'(2);
      end
      ACT_READ_START: begin
        // back to data output mode after the status poll
        list_d[0] = mk(KIND_CMD, NAND_READ_1);
        list_d[1] = mk(KIND_STROBE, 8'h00);
        n_d = CNT_W'(2);
      end
      ACT_FINISH: list_d[0] = mk(KIND_DONE, 8'h00);
      ACT_PROG_BYTE, ACT_SPR_BYTE: list_d[0] = mk(KIND_WDATA, data);
      ACT_PROG_TO_SPR: begin
        list_d[0] = mk(KIND_WDATA, data);
        list_d[1] = mk(KIND_CMD, NAND_CHG_WCOL);
        list_d[2] = mk(KIND_ADDR, spare_column_q[7:0]);
        list_d[3] = mk(KIND_ADDR, spare_column_q[15:8]);
        n_d = CNT_W'(4);
      end
      ACT_SPR_END: begin
        list_d[0] = mk(KIND_WDATA, data);
        list_d[1] = mk(KIND_CMD, NAND_PROG_2);
        list_d[2] = mk(KIND_CMD, NAND_STATUS);
        list_d[3] = mk(KIND_STROBE, 8'h00);
        n_d = CNT_W'(4);
      end
      ACT_RD_BYTE, ACT_RSPR_BYTE: begin
        list_d[0] = mk(KIND_HOST, data);
        list_d[1] = mk(KIND_STROBE, 8'h00);
        n_d = CNT_W'(2);
      end
      ACT_RD_TO_SPR: begin
        list_d[0] = mk(KIND_HOST, data);
        list_d[1] = mk(KIND_CMD, NAND_CHG_RCOL_1);
        list_d[2] = mk(KIND_ADDR, spare_column_q[7:0]);
        list_d[3] = mk(KIND_ADDR, spare_column_q[15:8]);
        list_d[4] = mk(KIND_CMD, NAND_CHG_RCOL_2);
        list_d[5] = mk(KIND_STROBE, 8'h00);
        n_d = CNT_W'(6);
      end
      ACT_RSPR_END: begin
        list_d[0] = mk(KIND_HOST, data);
        list_d[1] = mk(KIND_DONE, 8'h00);
        n_d = CNT_W'(2);
      end
      default: list_d[0] = mk(KIND_REJECT, 8'h00);
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bc_q         <= '0;
      op_is_read_q <= 1'b0;
      ce_q         <= 1'b0;
      cnt_q        <= '0;
      run_ce_q     <= 1'b0;
    end else if (in_acc) begin
      phase_q      <= phase_d;
      bc_q         <= bc_d;
      op_is_read_q <= op_is_read_d;
      ce_q         <= ce_d;
      cnt_q        <= n_d;
      // chip enable seen by every word of the run except done
      run_ce_q     <= ce_d || ce_q;
    end else if (out_acc) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // result payload: load on accept, shift toward the head on take
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_q <= list_d;
    end else if (out_acc) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) buf_q[i] <= buf_q[i + 1];
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = buf_q[0].kind;
  assign m_axis_tlast  = (cnt_q == CNT_W'(1));
  assign m_axis_tdata  = {7'b0, run_ce_q && (buf_q[0].kind != KIND_DONE), buf_q[0].bus_byte};

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("result count out of range");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (cnt_q <= CNT_W'(1)))
    else $error("input taken while earlier results pending");

  a_idle_ce_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> !ce_q)
    else $error("chip enable held in idle");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PROG_PAY || phase_q == PH_READ_PAY) |-> (bc_q < BC_W'(PAYLOAD_BYTES)))
    else $error("payload byte count overran");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted word gave no result");
`endif

endmodule

`default_nettype wire
